// ----- hdl/gms_pkg.sv -----
// ----------------------------------------------------------------------------
// gms_pkg
// Shared types, constants and the control program of the Metropolis sampler.
// ----------------------------------------------------------------------------
package gms_pkg;

  // Fixed-point formats.
  localparam int FRAC_BITS = 12;
  localparam int UNIF_BITS = 16;
  localparam int POS_W     = 16;
  localparam int SW_W      = 14;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [SW_W-1:0]  STEP_WIDTH_RESET = SW_W'(4096);
  localparam logic [POS_W-1:0] START_POS_RESET  = '0;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STEP_WIDTH     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_START_POSITION = 1'b1;

  // Shared multiplier: signed operands wide enough for a Q31 value of one.
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // Exponential: t = D / 2^(2F+1); g = t/16 in Q31 is D shifted left by two.
  localparam int EXP_SHIFT = 2 * FRAC_BITS + 1;
  localparam int G_LSHIFT  = 31 - (EXP_SHIFT + 4);
  localparam int G_W       = 31;
  localparam logic [31:0] DD_LIMIT = 32'(12) << EXP_SHIFT;
  localparam int TERMS     = 12;
  localparam int SQUARINGS = 4;

  // Serial divider by the term index: eight quotient bits per cycle.
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = 32 / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Program counter and named program steps.
  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] STEP_FIRST   = 5'd0;
  localparam logic [PC_W-1:0] STEP_MUL_TG  = 5'd6;
  localparam logic [PC_W-1:0] STEP_DIV     = 5'd8;
  localparam logic [PC_W-1:0] STEP_MUL_EE  = 5'd11;
  localparam logic [PC_W-1:0] STEP_FINISH  = 5'd14;
  localparam logic [PC_W-1:0] STEP_ACCEPT  = 5'd15;
  localparam logic [PC_W-1:0] STEP_REJECT  = 5'd16;
  localparam logic [PC_W-1:0] STEP_RESTART = 5'd17;
  localparam logic [PC_W-1:0] STEP_LAST    = STEP_RESTART;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_MUL_STEP,
    OP_MUL_XSQ,
    OP_MUL_XPSQ,
    OP_DIFF,
    OP_EXP_INIT,
    OP_MUL_TG,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_ACCUM,
    OP_CLAMP,
    OP_MUL_EE,
    OP_ROUND_E,
    OP_DECIDE,
    OP_FINISH,
    OP_SET_ACC,
    OP_SET_REJ,
    OP_RESTART
  } uop_e;

  typedef enum logic [3:0] {
    CND_NEXT,
    CND_ALWAYS,
    CND_RESTART,
    CND_DD_LE0,
    CND_DD_BIG,
    CND_DIV_MORE,
    CND_TERMS_MORE,
    CND_SQ_MORE,
    CND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    uop_e             op;
    cond_e            cond;
    logic [PC_W-1:0]  target;
  } ucw_t;

  typedef struct packed {
    logic load;
    uop_e op;
  } ctrl_t;

  typedef struct packed {
    logic restart;
    logic dd_le0;
    logic dd_big;
    logic div_last;
    logic terms_done;
    logic squares_done;
    logic out_busy;
  } status_t;

  // Control store. Each step drives one datapath operation and may branch.
  function automatic ucw_t ucode(logic [PC_W-1:0] pc);
    ucw_t w;
    w = '{OP_NOP, CND_NEXT, STEP_FIRST};
    unique case (pc)
      5'd0:  w = '{OP_MUL_STEP, CND_RESTART,    STEP_RESTART};
      5'd1:  w = '{OP_MUL_XSQ,  CND_NEXT,       STEP_FIRST};
      5'd2:  w = '{OP_MUL_XPSQ, CND_NEXT,       STEP_FIRST};
      5'd3:  w = '{OP_DIFF,     CND_NEXT,       STEP_FIRST};
      5'd4:  w = '{OP_NOP,      CND_DD_LE0,     STEP_ACCEPT};
      5'd5:  w = '{OP_EXP_INIT, CND_DD_BIG,     STEP_REJECT};
      5'd6:  w = '{OP_MUL_TG,   CND_NEXT,       STEP_FIRST};
      5'd7:  w = '{OP_DIV_LOAD, CND_NEXT,       STEP_FIRST};
      5'd8:  w = '{OP_DIV_STEP, CND_DIV_MORE,   STEP_DIV};
      5'd9:  w = '{OP_ACCUM,    CND_TERMS_MORE, STEP_MUL_TG};
      5'd10: w = '{OP_CLAMP,    CND_NEXT,       STEP_FIRST};
      5'd11: w = '{OP_MUL_EE,   CND_NEXT,       STEP_FIRST};
      5'd12: w = '{OP_ROUND_E,  CND_SQ_MORE,    STEP_MUL_EE};
      5'd13: w = '{OP_DECIDE,   CND_NEXT,       STEP_FIRST};
      5'd14: w = '{OP_FINISH,   CND_OUT_BUSY,   STEP_FINISH};
      5'd15: w = '{OP_SET_ACC,  CND_ALWAYS,     STEP_FINISH};
      5'd16: w = '{OP_SET_REJ,  CND_ALWAYS,     STEP_FINISH};
      5'd17: w = '{OP_RESTART,  CND_ALWAYS,     STEP_FINISH};
      default: w = '{OP_NOP, CND_NEXT, STEP_FIRST};
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/gms_divider.sv -----
// ----------------------------------------------------------------------------
// gms_divider
// Restoring divider of a 32-bit value by a small divisor, eight bits a cycle.
// ----------------------------------------------------------------------------
module gms_divider import gms_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  logic        step_i,
  input  logic [31:0] num_i,
  input  logic [3:0]  den_i,
  output logic [31:0] quo_o,
  output logic        last_o
);

  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]          shr_q, shr_d;
  logic [3:0]           rem_q, rem_d;

  // The shift register starts as the dividend and ends as the quotient.
  always_comb begin
    logic [4:0] r5;
    shr_d = shr_q;
    rem_d = rem_q;
    for (int i = 0; i < DIV_BITS; i++) begin
      r5    = {rem_d, shr_d[31]};
      shr_d = {shr_d[30:0], 1'b0};
      if (r5 >= {1'b0, den_i}) begin
        r5       = r5 - {1'b0, den_i};
        shr_d[0] = 1'b1;
      end
      rem_d = r5[3:0];
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (load_i) begin
      cnt_d = '0;
    end else if (step_i) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      shr_q <= num_i;
      rem_q <= '0;
    end else if (step_i) begin
      shr_q <= shr_d;
      rem_q <= rem_d;
    end
  end

  assign quo_o  = shr_q;
  assign last_o = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

endmodule

// ----- hdl/gms_datapath.sv -----
// ----------------------------------------------------------------------------
// gms_datapath
// Registers, shared multiplier and output stage, driven one operation a step.
// ----------------------------------------------------------------------------
module gms_datapath import gms_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  ctrl_t                ctrl_i,
  input  logic                 restart_i,
  input  logic [15:0]          step_uniform_i,
  input  logic [15:0]          accept_uniform_i,
  input  logic                 out_stall_i,
  output status_t              status_o,
  output logic                 out_valid_o,
  output logic signed [15:0]   sample_o,
  output logic                 accepted_o
);

  logic [SW_W-1:0]         step_width_q;
  logic signed [POS_W-1:0] start_q;
  logic signed [POS_W-1:0] pos_q;
  logic                    restart_q;
  logic [15:0]             u_q;
  logic [15:0]             a_q;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [POS_W-1:0]  xp_q;
  logic [30:0]              x2_q;
  logic signed [31:0]       dd_q;
  logic [G_W-1:0]           g_q;
  logic [31:0]              term_q;
  logic signed [33:0]       sum_q;
  logic [31:0]              e_q;
  logic [3:0]               k_q;
  logic                     acc_q;

  logic                     out_valid_q;
  logic signed [POS_W-1:0]  out_sample_q;
  logic                     out_accepted_q;

  logic                     mul_en;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic [32:0]              d_step;
  logic signed [35:0]       off_sum;
  logic signed [19:0]       xp_sum;
  logic signed [POS_W-1:0]  xp_sat;
  logic signed [31:0]       dd_d;
  logic [31:0]              quo;
  logic [63:0]              e_rnd;
  logic [47:0]              p_sum;
  logic [16:0]              prob;
  logic                     out_busy;
  logic                     commit;
  logic                     div_last;

  assign out_busy = out_valid_q && out_stall_i;
  assign commit   = (ctrl_i.op == OP_FINISH) && !out_busy;

  // Offset 2u-1 scaled to the full uniform range.
  assign d_step = {16'b0, u_q, 1'b0} - 33'h1_0000;

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (ctrl_i.op)
      OP_MUL_STEP: begin
        mul_en = 1'b1;
        mul_a  = $signed({{(MUL_W-SW_W){1'b0}}, step_width_q});
        mul_b  = $signed(d_step);
      end
      OP_MUL_XSQ: begin
        mul_en = 1'b1;
        mul_a  = {{(MUL_W-POS_W){pos_q[POS_W-1]}}, pos_q};
        mul_b  = mul_a;
      end
      OP_MUL_XPSQ: begin
        mul_en = 1'b1;
        mul_a  = {{(MUL_W-POS_W){xp_q[POS_W-1]}}, xp_q};
        mul_b  = mul_a;
      end
      OP_MUL_TG: begin
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, term_q});
        mul_b  = $signed({2'b0, g_q});
      end
      OP_MUL_EE: begin
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, e_q});
        mul_b  = mul_a;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Proposal: round the scaled offset half up, then saturate the sum.
  always_comb begin
    off_sum = $signed(prod_q[35:0]) + 36'sd32768;
    xp_sum  = {{4{pos_q[POS_W-1]}}, pos_q} + off_sum[35:16];
    if (xp_sum > 20'sd32767) begin
      xp_sat = 16'sh7FFF;
    end else if (xp_sum < -20'sd32768) begin
      xp_sat = 16'sh8000;
    end else begin
      xp_sat = xp_sum[15:0];
    end
  end

  assign dd_d  = $signed({1'b0, prod_q[30:0]}) - $signed({1'b0, x2_q});
  assign e_rnd = prod_q[63:0] + 64'h4000_0000;
  assign p_sum = {e_q, 16'b0} + 48'h4000_0000;
  assign prob  = p_sum[47:31];

  gms_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (ctrl_i.op == OP_DIV_LOAD),
    .step_i (ctrl_i.op == OP_DIV_STEP),
    .num_i  (prod_q[62:31]),
    .den_i  (k_q),
    .quo_o  (quo),
    .last_o (div_last)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_width_q <= STEP_WIDTH_RESET;
      start_q      <= START_POS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_STEP_WIDTH:     step_width_q <= cfg_data_i[SW_W-1:0];
        REG_START_POSITION: start_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      restart_q <= restart_i;
      u_q       <= step_uniform_i;
      a_q       <= accept_uniform_i;
    end
    if (mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    unique case (ctrl_i.op)
      OP_MUL_XSQ:  xp_q <= xp_sat;
      OP_MUL_XPSQ: x2_q <= prod_q[30:0];
      OP_DIFF:     dd_q <= dd_d;
      OP_EXP_INIT: begin
        g_q    <= {dd_q[G_W-1-G_LSHIFT:0], {G_LSHIFT{1'b0}}};
        term_q <= 32'h8000_0000;
        sum_q  <= 34'sh0_8000_0000;
        k_q    <= 4'd1;
      end
      OP_ACCUM: begin
        term_q <= quo;
        // Odd powers of -g subtract, even powers add.
        if (k_q[0]) begin
          sum_q <= sum_q - $signed({2'b0, quo});
        end else begin
          sum_q <= sum_q + $signed({2'b0, quo});
        end
        k_q <= k_q + 1'b1;
      end
      OP_CLAMP: begin
        if (sum_q[33]) begin
          e_q <= '0;
        end else if (sum_q > 34'sh0_8000_0000) begin
          e_q <= 32'h8000_0000;
        end else begin
          e_q <= sum_q[31:0];
        end
        k_q <= '0;
      end
      OP_ROUND_E: begin
        e_q <= e_rnd[62:31];
        k_q <= k_q + 1'b1;
      end
      OP_RESTART:  xp_q <= start_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (ctrl_i.op)
        OP_DECIDE:  acc_q <= (prob > {1'b0, a_q});
        OP_SET_ACC: acc_q <= 1'b1;
        OP_SET_REJ: acc_q <= 1'b0;
        OP_RESTART: acc_q <= 1'b1;
        default: ;
      endcase
      if (commit) begin
        out_valid_q <= 1'b1;
        if (acc_q) begin
          pos_q <= xp_q;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_sample_q   <= acc_q ? xp_q : pos_q;
      out_accepted_q <= acc_q;
    end
  end

  assign status_o.restart      = restart_q;
  assign status_o.dd_le0       = dd_q[31] || (dd_q == '0);
  assign status_o.dd_big       = !dd_q[31] && (dd_q >= $signed(DD_LIMIT));
  assign status_o.div_last     = div_last;
  assign status_o.terms_done   = (k_q == 4'(TERMS));
  assign status_o.squares_done = (k_q == 4'(SQUARINGS - 1));
  assign status_o.out_busy     = out_busy;

  assign out_valid_o = out_valid_q;
  assign sample_o    = out_sample_q;
  assign accepted_o  = out_accepted_q;

`ifndef SYNTHESIS
  a_reject_keeps_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && !acc_q |=> $stable(pos_q))
    else $error("rejected proposal changed the position");

  a_commit_shows_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q && (out_sample_q == pos_q))
    else $error("emitted sample differs from the chain position");
`endif

endmodule

// ----- hdl/gms_sequencer.sv -----
// ----------------------------------------------------------------------------
// gms_sequencer
// Step counter over the control store with conditional branches.
// ----------------------------------------------------------------------------
module gms_sequencer import gms_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  status_t status_i,
  output logic    in_stall_o,
  output ctrl_t   ctrl_o
);

  logic            busy_q, busy_d;
  logic [PC_W-1:0] pc_q, pc_d;
  ucw_t            word;
  logic            taken;

  assign word = ucode(pc_q);

  always_comb begin
    unique case (word.cond)
      CND_NEXT:       taken = 1'b0;
      CND_ALWAYS:     taken = 1'b1;
      CND_RESTART:    taken = status_i.restart;
      CND_DD_LE0:     taken = status_i.dd_le0;
      CND_DD_BIG:     taken = status_i.dd_big;
      CND_DIV_MORE:   taken = !status_i.div_last;
      CND_TERMS_MORE: taken = !status_i.terms_done;
      CND_SQ_MORE:    taken = !status_i.squares_done;
      CND_OUT_BUSY:   taken = status_i.out_busy;
      default:        taken = 1'b0;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (!busy_q) begin
      if (in_valid_i) begin
        busy_d = 1'b1;
        pc_d   = STEP_FIRST;
      end
    end else if (word.op == OP_FINISH && !status_i.out_busy) begin
      busy_d = 1'b0;
      pc_d   = STEP_FIRST;
    end else if (taken) begin
      pc_d = word.target;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= STEP_FIRST;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  assign in_stall_o = busy_q;
  assign ctrl_o.load = in_valid_i && !busy_q;
  assign ctrl_o.op   = busy_q ? word.op : OP_NOP;

`ifndef SYNTHESIS
  a_start_at_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !busy_q |=> busy_q && (pc_q == STEP_FIRST))
    else $error("item taken but program did not start at its first step");

  a_pc_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> pc_q <= STEP_LAST)
    else $error("step counter left the program");
`endif

endmodule

// ----- hdl/gaussian_metropolis_sampler.sv -----
// ----------------------------------------------------------------------------
// gaussian_metropolis_sampler
// Random-walk Metropolis sampler of the standard normal density, Q3.12.
// ----------------------------------------------------------------------------
// Usage: each input item carries a restart bit and two 16-bit uniforms; every
// item yields exactly one result item (sample, accepted). Both channels use
// valid/stall; an item moves on a rising edge with valid high and stall low.
// Registers step_width (index 0) and start_position (index 1) are written
// through cfg_we_i/cfg_index_i/cfg_data_i; the user must write them only while
// the block is idle, which the block itself does not enforce.
// One item is processed at a time; in_stall_o is high while it is at work.
// The path of an item depends on its case: a restart, a proposal that does not
// raise the energy, an acceptance probability of zero, or the exponential, the
// longest case, set by the twelve-term series, each term one pass through the
// shared 33x33 multiplier and a serial divide by the term index. The next input
// item can be taken in the cycle after the edge that raises out_valid_o.
// A finished result waits in the output register; if the receiver stalls,
// the next item is still taken and runs until its own result is due.
// Reset clears the position to zero and restores the register defaults.
// ----------------------------------------------------------------------------
module gaussian_metropolis_sampler import gms_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 restart_i,
  input  logic [15:0]          step_uniform_i,
  input  logic [15:0]          accept_uniform_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [15:0]   sample_o,
  output logic                 accepted_o
);

  ctrl_t   ctrl;
  status_t status;

  gms_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .ctrl_o     (ctrl)
  );

  gms_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .ctrl_i           (ctrl),
    .restart_i        (restart_i),
    .step_uniform_i   (step_uniform_i),
    .accept_uniform_i (accept_uniform_i),
    .out_stall_i      (out_stall_i),
    .status_o         (status),
    .out_valid_o      (out_valid_o),
    .sample_o         (sample_o),
    .accepted_o       (accepted_o)
  );

endmodule

// ----- dv/gms_checker.sv -----
// ----------------------------------------------------------------------------
// gms_checker
// Watches the configuration port and both item channels of the Metropolis
// sampler, keeps its own copy of the chain and the registers, predicts each
// (sample, accepted) result and compares it with what the block emits.
// ----------------------------------------------------------------------------
module gms_checker import gms_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic                 restart_i,
  input  logic [15:0]          step_uniform_i,
  input  logic [15:0]          accept_uniform_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic signed [15:0]   sample_i,
  input  logic                 accepted_i,
  output int                   pending_o,
  output int                   errors_o
);

  localparam int DD_SHIFT = 2 * FRAC_BITS + 1;

  typedef struct packed {
    logic signed [POS_W-1:0] sample;
    logic                    accepted;
  } draw_t;

  draw_t                   expected_draws[$];
  logic [SW_W-1:0]         step_width;
  logic signed [POS_W-1:0] start_position;
  logic signed [POS_W-1:0] chain_pos;

  task automatic report_mismatch(input string what);
    errors_o++;
    $display("%0t: MISMATCH: %s", $time, what);
  endtask

  // Moves the chain by one item and returns the result it should produce.
  function automatic draw_t advance_chain(input logic rs,
                                          input logic [UNIF_BITS-1:0] su,
                                          input logic [UNIF_BITS-1:0] au);
    draw_t       d;
    longint      off;
    longint      prop;
    longint      dd;
    longint      sum;
    logic [63:0] g;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] p;
    int          k;
    d.accepted = 1'b0;
    if (rs) begin
      chain_pos  = start_position;
      d.accepted = 1'b1;
    end else begin
      // Offset step_width*(2u-1), rounded half up; >>> floors negative values.
      off = (longint'(step_width) * (2 * longint'(su) - (longint'(1) << UNIF_BITS))
             + (longint'(1) << (UNIF_BITS - 1))) >>> UNIF_BITS;
      prop = longint'(chain_pos) + off;
      if (prop > 32767) prop = 32767;
      if (prop < -32768) prop = -32768;
      dd = prop * prop - longint'(chain_pos) * longint'(chain_pos);
      if (dd <= 0) begin
        d.accepted = 1'b1;
      end else begin
        p = '0;
        if (dd < (longint'(12) << DD_SHIFT)) begin
          // exp(-t) as exp(-t/16)^16: a twelve-term series in Q31, then four squarings.
          g    = 64'(dd) << (27 - DD_SHIFT);
          term = 64'd1 << 31;
          sum  = longint'(term);
          for (k = 1; k <= 12; k++) begin
            term = ((term * g) >> 31) / 64'(k);
            if (k % 2 == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
          end
          if (sum < 0) sum = 0;
          if (sum > (longint'(1) << 31)) sum = longint'(1) << 31;
          e = 64'(sum);
          repeat (4) e = (e * e + (64'd1 << 30)) >> 31;
          p = (e * 64'd65536 + (64'd1 << 30)) >> 31;
        end
        d.accepted = (p > 64'(au));
      end
      if (d.accepted) chain_pos = 16'(prop);
    end
    d.sample = chain_pos;
    return d;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    draw_t want;
    if (!rst_ni) begin
      step_width     = STEP_WIDTH_RESET;
      start_position = START_POS_RESET;
      chain_pos      = '0;
      expected_draws.delete();
      pending_o      = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_STEP_WIDTH) step_width = cfg_data_i[SW_W-1:0];
        else if (cfg_index_i == REG_START_POSITION) start_position = cfg_data_i;
      end
      // Results are checked before this edge's input item is predicted.
      if (out_valid_i && !out_stall_i) begin
        if (expected_draws.size() == 0) begin
          report_mismatch($sformatf("result (%0d, %0b) with nothing expected",
                                    sample_i, accepted_i));
        end else begin
          want = expected_draws.pop_front();
          if (sample_i !== want.sample)
            report_mismatch($sformatf("sample expected %0d, got %0d",
                                      want.sample, sample_i));
          if (accepted_i !== want.accepted)
            report_mismatch($sformatf("accepted expected %0b, got %0b",
                                      want.accepted, accepted_i));
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_draws.push_back(advance_chain(restart_i, step_uniform_i,
                                               accept_uniform_i));
      pending_o = expected_draws.size();
    end
  end

endmodule

// ----- dv/tb_gaussian_metropolis_sampler.sv -----
// ----------------------------------------------------------------------------
// tb_gaussian_metropolis_sampler
// Drives the Metropolis sampler with directed and random items under random
// sender gaps and receiver stalls, across several register settings, and
// gives the verdict from the failure and pending counts of the checker.
// ----------------------------------------------------------------------------
module tb_gaussian_metropolis_sampler;
  import gms_pkg::*;

  localparam int RESET_CYCLES   = 10;
  localparam int DRAIN_CYCLES   = 120;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_ITEMS    = 150;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_STEP_WIDTH;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 restart = 1'b0;
  logic [15:0]          step_uniform = '0;
  logic [15:0]          accept_uniform = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [15:0]   sample;
  logic                 accepted;

  int pending;
  int errors;
  int gap_max = 9;
  int stall_max = 9;
  int idle_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  gaussian_metropolis_sampler DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .restart_i        (restart),
    .step_uniform_i   (step_uniform),
    .accept_uniform_i (accept_uniform),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .sample_o         (sample),
    .accepted_o       (accepted)
  );

  gms_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .restart_i        (restart),
    .step_uniform_i   (step_uniform),
    .accept_uniform_i (accept_uniform),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .sample_i         (sample),
    .accepted_i       (accepted),
    .pending_o        (pending),
    .errors_o         (errors)
  );

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(input logic rs, input logic [15:0] su,
                           input logic [15:0] au);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    restart        <= rs;
    step_uniform   <= su;
    accept_uniform <= au;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain_chain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Registers are only written once every outstanding result has come back.
  task automatic write_regs(input logic [CFG_W-1:0] sw_data,
                            input logic [CFG_W-1:0] sp_data);
    drain_chain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_STEP_WIDTH;
    cfg_data  <= sw_data;
    @(negedge clk);
    cfg_index <= REG_START_POSITION;
    cfg_data  <= sp_data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int n;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      n = $urandom_range(0, stall_max);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [SW_W-1:0]  sw;
    logic [CFG_W-1:0] sw_data;
    logic [CFG_W-1:0] sp;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Register defaults: start at zero, half width 1.0.
    send_item(1'b1, 16'h0000, 16'h0000);
    send_item(1'b0, 16'h8000, 16'hFFFF);   // zero offset, equal energy
    send_item(1'b0, 16'hFFFF, 16'h0000);   // uphill, accept uniform at zero
    send_item(1'b0, 16'h0000, 16'hFFFF);   // back downhill
    send_item(1'b0, 16'h0000, 16'hFFFF);   // uphill against the top uniform

    // Widest step from the top of the range: saturation at the upper bound.
    write_regs({2'b11, 14'h3FFF}, 16'h7FFF);
    send_item(1'b1, 16'hFFFF, 16'hFFFF);
    send_item(1'b0, 16'hFFFF, 16'h0000);
    send_item(1'b0, 16'h0000, 16'h0000);

    // Zero width from the bottom of the range.
    write_regs(16'h0000, 16'h8000);
    send_item(1'b1, 16'h0000, 16'h0000);
    send_item(1'b0, 16'h0000, 16'hFFFF);
    send_item(1'b0, 16'hFFFF, 16'h0000);

    // From 4.0: a jump to 8.0 has zero probability, smaller ones go through exp.
    write_regs({2'b00, 14'h3FFF}, 16'h4000);
    send_item(1'b1, 16'h1234, 16'h5678);
    send_item(1'b0, 16'hFFFF, 16'h0000);
    send_item(1'b0, 16'h0000, 16'hFFFF);
    send_item(1'b0, 16'hC000, 16'h0000);
    send_item(1'b0, 16'hC000, 16'hFFFF);
    send_item(1'b0, 16'hA000, 16'h8000);

    // Half width 0.5 from the bottom: saturation at the lower bound.
    write_regs({2'b10, 14'd2048}, 16'h8000);
    send_item(1'b1, 16'h0000, 16'h0000);
    send_item(1'b0, 16'h0000, 16'h0000);
    send_item(1'b0, 16'hFFFF, 16'hFFFF);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 5))
        0:       sw = '0;
        1:       sw = '1;
        2:       sw = SW_W'($urandom);
        default: sw = SW_W'($urandom_range(512, 8192));
      endcase
      case ($urandom_range(0, 4))
        0:       sp = 16'h8000;
        1:       sp = 16'h7FFF;
        2:       sp = CFG_W'($urandom);
        default: sp = CFG_W'($urandom_range(0, 32767)) - 16'd16384;
      endcase
      sw_data           = CFG_W'($urandom);
      sw_data[SW_W-1:0] = sw;
      write_regs(sw_data, sp);
      send_item(1'b1, 16'($urandom), 16'($urandom));
      repeat (PHASE_ITEMS)
        send_item($urandom_range(0, 31) == 0, 16'($urandom), 16'($urandom));
    end

    drain_chain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/gms_pkg.sv
hdl/gms_divider.sv
hdl/gms_datapath.sv
hdl/gms_sequencer.sv
hdl/gaussian_metropolis_sampler.sv
dv/gms_checker.sv
dv/tb_gaussian_metropolis_sampler.sv
